@@ rtl/htfd_pkg.sv @@
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 byte step for the measurement
// frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam int DATA_W    = 8;
  localparam int RAW_W     = 16;
  localparam int VALUE_W   = 15;
  localparam int STATUS_W  = 2;
  localparam int COEF_W    = 15;
  localparam int PRODUCT_W = RAW_W + COEF_W;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [DATA_W-1:0] CRC8_GEN = 8'h31;
  localparam int                KIND_BIT = 1;

  localparam logic [COEF_W-1:0] TEMP_COEF = 15'd17572;
  localparam logic [COEF_W-1:0] HUM_COEF  = 15'd12500;
  localparam logic signed [VALUE_W:0] TEMP_OFFSET = -16'sd4685;
  localparam logic signed [VALUE_W:0] HUM_OFFSET  = -16'sd600;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CRC_ERR  = 2'd1,
    STATUS_KIND_ERR = 2'd2
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [RAW_W-1:0]   raw;
    logic               kind;
  } frame_t;

  function automatic logic [DATA_W-1:0] crc8_step(input logic [DATA_W-1:0] crc,
                                                  input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < DATA_W; k++) begin
      if (c[DATA_W-1]) begin
        c = {c[DATA_W-2:0], 1'b0} ^ CRC8_GEN;
      end else begin
        c = {c[DATA_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/htfd_front.sv @@
// ----------------------------------------------------------------------------
// htfd_front
// Accepts frame bytes, tracks position and running CRC, and classifies each
// completed frame into a record for the conversion stage.
// ----------------------------------------------------------------------------
module htfd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [htfd_pkg::DATA_W-1:0]  data_byte,
  input  logic                         frame_start,
  input  logic                         measure_kind,
  output logic                         frame_valid,
  output htfd_pkg::frame_t             frame
);
  import htfd_pkg::*;

  typedef enum logic [1:0] {
    POS_HIGH = 2'd0,
    POS_LOW  = 2'd1,
    POS_CRC  = 2'd2
  } pos_t;

  pos_t              pos;
  logic [DATA_W-1:0] crc;
  logic [DATA_W-1:0] high_byte;
  logic [DATA_W-1:0] low_byte;
  logic              kind;

  logic [RAW_W-1:0]  raw_next;
  status_t           status_next;
  logic              is_first;
  logic              is_last;

  assign raw_next = {high_byte, low_byte};
  assign is_first = frame_start || (pos != POS_LOW && pos != POS_CRC);
  assign is_last  = !is_first && pos == POS_CRC;

  always_comb begin
    if (crc != data_byte) begin
      status_next = STATUS_CRC_ERR;
    end else if (raw_next[KIND_BIT] != kind) begin
      status_next = STATUS_KIND_ERR;
    end else begin
      status_next = STATUS_OK;
    end
  end

  assign frame_valid  = accept && is_last;
  assign frame.status = status_next;
  assign frame.raw    = raw_next;
  assign frame.kind   = kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_HIGH;
      crc       <= '0;
      high_byte <= '0;
      low_byte  <= '0;
      kind      <= 1'b0;
    end else if (accept) begin
      if (is_first) begin
        high_byte <= data_byte;
        kind      <= measure_kind;
        crc       <= crc8_step('0, data_byte);
        pos       <= POS_LOW;
      end else if (pos == POS_LOW) begin
        low_byte <= data_byte;
        crc      <= crc8_step(crc, data_byte);
        pos      <= POS_CRC;
      end else begin
        crc <= '0;
        pos <= POS_HIGH;
      end
    end
  end

endmodule

@@ rtl/htfd_queue.sv @@
// ----------------------------------------------------------------------------
// htfd_queue
// Short queue of classified frame records between the front and the
// conversion stage.
// ----------------------------------------------------------------------------
module htfd_queue #(
  parameter int DEPTH = htfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  htfd_pkg::frame_t  wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              rd_valid,
  output htfd_pkg::frame_t  rd_data
);
  import htfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full     = count == CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/htfd_back.sv @@
// ----------------------------------------------------------------------------
// htfd_back
// Converts a frame record to hundredths and holds it in the output register
// until popped.
// ----------------------------------------------------------------------------
module htfd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  htfd_pkg::frame_t                    in_frame,
  output logic                                in_take,
  output logic                                empty,
  input  logic                                pop,
  output logic [htfd_pkg::STATUS_W-1:0]       status,
  output logic [htfd_pkg::RAW_W-1:0]          raw_word,
  output logic signed [htfd_pkg::VALUE_W-1:0] scaled_value,
  output logic                                result_kind
);
  import htfd_pkg::*;

  logic                     out_valid;
  logic [RAW_W-1:0]         mant;
  logic [COEF_W-1:0]        coef;
  logic [PRODUCT_W-1:0]     product;
  logic [VALUE_W-1:0]       frac;
  logic signed [VALUE_W:0]  offset;
  logic signed [VALUE_W:0]  value_next;

  assign mant       = {in_frame.raw[RAW_W-1:2], 2'b00};
  assign coef       = in_frame.kind ? HUM_COEF : TEMP_COEF;
  assign offset     = in_frame.kind ? HUM_OFFSET : TEMP_OFFSET;
  assign product    = PRODUCT_W'(mant) * PRODUCT_W'(coef);
  assign frac       = product[PRODUCT_W-1:RAW_W];
  assign value_next = offset + $signed({1'b0, frac});

  assign in_take = in_valid && (!out_valid || pop);
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      status       <= in_frame.status;
      raw_word     <= in_frame.raw;
      scaled_value <= value_next[VALUE_W-1:0];
      result_kind  <= in_frame.kind;
    end
  end

endmodule

@@ rtl/humidity_temp_frame_decoder_core.sv @@
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_core
// Decodes 3-byte humidity/temperature frames (two data bytes, CRC-8 0x31)
// into raw word, status and a value in hundredths.
//
//   channel  | handshake      | payload
//   ---------+----------------+-------------------------------------------
//   input    | push / full    | data_byte, frame_start, measure_kind
//   result   | pop / empty    | status, raw_word, scaled_value, result_kind
//
// One byte is accepted per cycle while full is low. The front writes each
// CRC byte's record to the queue; the multiplier stage loads it into the
// output register once that is free or popped. Reset is synchronous and
// clears position, CRC, queue and output valid flag. full rises only when
// the record queue is full while the output register waits on pop.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_core #(
  parameter int QUEUE_DEPTH = htfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [htfd_pkg::DATA_W-1:0]         data_byte,
  input  logic                                frame_start,
  input  logic                                measure_kind,
  output logic                                empty,
  input  logic                                pop,
  output logic [htfd_pkg::STATUS_W-1:0]       status,
  output logic [htfd_pkg::RAW_W-1:0]          raw_word,
  output logic signed [htfd_pkg::VALUE_W-1:0] scaled_value,
  output logic                                result_kind
);
  import htfd_pkg::*;

  logic   accept;
  logic   frame_valid;
  frame_t frame;
  logic   q_valid;
  frame_t q_frame;
  logic   q_take;

  assign accept = push && !full;

  htfd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .frame_start  (frame_start),
    .measure_kind (measure_kind),
    .frame_valid  (frame_valid),
    .frame        (frame)
  );

  htfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (frame_valid),
    .wr_data  (frame),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_data  (q_frame)
  );

  htfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_frame     (q_frame),
    .in_take      (q_take),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .raw_word     (raw_word),
    .scaled_value (scaled_value),
    .result_kind  (result_kind)
  );

endmodule
